// File: hw/rtl/gbch_pkg.sv
package gbch_pkg;

  localparam int unsigned PREFIX_DEPTH_DEF = 128;
  localparam int unsigned RES_W            = 60;
  localparam int unsigned SYM_W            = 5;
  localparam int unsigned CHECK_LEN        = 12;

  typedef logic [RES_W-1:0] res_t;
  typedef logic [SYM_W-1:0] sym_t;

  localparam res_t GEN [5] = '{
    60'h07d52fba40bd886,
    60'h05e8dbf1a03950c,
    60'h01c3a3c74072a18,
    60'h0385d72fa0e5139,
    60'h07093e5a608865b
  };
  localparam res_t LONG_CONST = 60'h455972a3350f7a1;
  localparam res_t RES_ONE    = 60'h1;

  localparam logic [1:0] FUNC_PREFIX = 2'd0;
  localparam logic [1:0] FUNC_DATA   = 2'd1;
  localparam logic [1:0] FUNC_END    = 2'd2;

  localparam logic [1:0] MODE_VERIFY      = 2'd0;
  localparam logic [1:0] MODE_CREATE_ONE  = 2'd1;
  localparam logic [1:0] MODE_CREATE_LONG = 2'd2;

  localparam logic [1:0] VERDICT_OK   = 2'd0;
  localparam logic [1:0] VERDICT_LONG = 2'd1;
  localparam logic [1:0] VERDICT_BAD  = 2'd2;
  localparam logic [1:0] VERDICT_ERR  = 2'd3;

  // One symbol step: drop the top symbol, shift in the new one, fold back.
  function automatic res_t feed(res_t res, sym_t sym);
    res_t       r;
    logic [4:0] top;
    top = res[RES_W-1:RES_W-SYM_W];
    r   = {res[RES_W-SYM_W-1:0], sym};
    for (int n = 0; n < 5; n++) begin
      if (top[n]) begin
        r = r ^ GEN[n];
      end
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/gf32_bch_checksum_engine_unit.sv
// Channel   | Ports                                                  | Handshake
// ----------+--------------------------------------------------------+-----------------------
// input     | in_func, in_prefix_char, in_data_symbol                | in_valid / in_ready
// result    | out_check_symbol, out_verdict, out_last                | out_valid / out_ready
// config    | cfg_wr_data (mode)                                     | cfg_wr_en, no wait
//
// A prefix character is fed and stored on acceptance, a data symbol fed once the prefix is flushed.
// The first data symbol or end request pays the flush: a zero feed in S_FZERO, then P stored
// prefix characters fed in S_FPRE, one prefix store read per cycle (registered read).
// End: verify or input error loads its verdict in S_FINISH; create runs S_FINISH, 12 zero feeds
// in S_ZERO, the constant in S_XOR, then 12 result symbols. One feed unit, one symbol a cycle.
// Reset is synchronous; the prefix store needs no clearing pass. A stalled result
// holds in the output register; new requests are taken once the last result is loaded.
module gf32_bch_checksum_engine_unit #(
  parameter int unsigned PREFIX_DEPTH = gbch_pkg::PREFIX_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     in_func,
  input  logic [7:0]     in_prefix_char,
  input  gbch_pkg::sym_t in_data_symbol,
  output logic           out_valid,
  input  logic           out_ready,
  output gbch_pkg::sym_t out_check_symbol,
  output logic [1:0]     out_verdict,
  output logic           out_last,
  input  logic           cfg_wr_en,
  input  logic [1:0]     cfg_wr_data
);
  import gbch_pkg::*;

  localparam int unsigned AW = (PREFIX_DEPTH > 1) ? $clog2(PREFIX_DEPTH) : 1;
  localparam int unsigned CW = $clog2(PREFIX_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(PREFIX_DEPTH);
  localparam logic [3:0] LAST_CNT = 4'(CHECK_LEN - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FZERO  = 3'd1;
  localparam logic [2:0] S_FPRE   = 3'd2;
  localparam logic [2:0] S_FINISH = 3'd3;
  localparam logic [2:0] S_ZERO   = 3'd4;
  localparam logic [2:0] S_XOR    = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0]    state_r, state_nxt;
  res_t          res_r, res_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          flushed_r, flushed_nxt;
  logic          err_r, err_nxt;
  logic          pend_end_r, pend_end_nxt;
  sym_t          pend_sym_r, pend_sym_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic [1:0]    mode_r;
  logic          out_valid_r, out_valid_nxt;
  sym_t          out_sym_r, out_sym_nxt;
  logic [1:0]    out_verdict_r, out_verdict_nxt;
  logic          out_last_r, out_last_nxt;

  sym_t          mem [PREFIX_DEPTH];
  sym_t          rd_data_r;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] idx_inc;
  logic          mem_we;

  logic          accept;
  logic          slot_free;
  logic          feed_en;
  sym_t          feed_sym;
  logic          load_out;
  sym_t          load_sym;
  logic [1:0]    load_verdict;
  logic          load_last;
  logic          clear;
  logic          create_mode;
  logic [1:0]    check_verdict;

  assign in_ready    = (state_r == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign slot_free   = !out_valid_r || out_ready;
  assign create_mode = (mode_r == MODE_CREATE_ONE) || (mode_r == MODE_CREATE_LONG);
  assign idx_inc     = idx_r + 1'b1;
  assign rd_addr     = (state_r == S_FPRE) ? idx_inc[AW-1:0] : '0;

  always_comb begin
    if (res_r == RES_ONE) begin
      check_verdict = VERDICT_OK;
    end else if (res_r == LONG_CONST) begin
      check_verdict = VERDICT_LONG;
    end else begin
      check_verdict = VERDICT_BAD;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    res_nxt      = res_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    flushed_nxt  = flushed_r;
    err_nxt      = err_r;
    pend_end_nxt = pend_end_r;
    pend_sym_nxt = pend_sym_r;
    cnt_nxt      = cnt_r;
    feed_en      = 1'b0;
    feed_sym     = '0;
    mem_we       = 1'b0;
    load_out     = 1'b0;
    load_sym     = '0;
    load_verdict = VERDICT_OK;
    load_last    = 1'b1;
    clear        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_func)
            FUNC_PREFIX: begin
              if (flushed_r || (count_r >= DEPTH_C)) begin
                err_nxt = 1'b1;
              end else begin
                feed_en   = 1'b1;
                feed_sym  = {2'b00, in_prefix_char[7:5]};
                mem_we    = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            FUNC_DATA: begin
              if (flushed_r) begin
                feed_en  = 1'b1;
                feed_sym = in_data_symbol;
              end else begin
                pend_end_nxt = 1'b0;
                pend_sym_nxt = in_data_symbol;
                state_nxt    = S_FZERO;
              end
            end
            FUNC_END: begin
              pend_end_nxt = 1'b1;
              state_nxt    = flushed_r ? S_FINISH : S_FZERO;
            end
            default: ;
          endcase
        end
      end
      S_FZERO: begin
        feed_en   = 1'b1;
        idx_nxt   = '0;
        state_nxt = S_FPRE;
      end
      S_FPRE: begin
        // rd_data_r holds entry idx_r, read the cycle before
        if (idx_r == count_r) begin
          flushed_nxt = 1'b1;
          if (pend_end_r) begin
            state_nxt = S_FINISH;
          end else begin
            feed_en   = 1'b1;
            feed_sym  = pend_sym_r;
            state_nxt = S_IDLE;
          end
        end else begin
          feed_en  = 1'b1;
          feed_sym = rd_data_r;
          idx_nxt  = idx_inc;
        end
      end
      S_FINISH: begin
        if (err_r) begin
          if (slot_free) begin
            load_out     = 1'b1;
            load_verdict = VERDICT_ERR;
            clear        = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else if (create_mode) begin
          cnt_nxt   = '0;
          state_nxt = S_ZERO;
        end else if (slot_free) begin
          load_out     = 1'b1;
          load_verdict = check_verdict;
          clear        = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_ZERO: begin
        feed_en = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_CNT) begin
          state_nxt = S_XOR;
        end
      end
      S_XOR: begin
        res_nxt   = res_r ^ ((mode_r == MODE_CREATE_ONE) ? RES_ONE : LONG_CONST);
        cnt_nxt   = '0;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // residue doubles as the output shift register
        if (slot_free) begin
          load_out  = 1'b1;
          load_sym  = res_r[RES_W-1:RES_W-SYM_W];
          load_last = (cnt_r == LAST_CNT);
          res_nxt   = {res_r[RES_W-SYM_W-1:0], {SYM_W{1'b0}}};
          cnt_nxt   = cnt_r + 1'b1;
          if (cnt_r == LAST_CNT) begin
            clear     = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (feed_en) begin
      res_nxt = feed(res_r, feed_sym);
    end
    if (clear) begin
      res_nxt     = RES_ONE;
      count_nxt   = '0;
      flushed_nxt = 1'b0;
      err_nxt     = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_sym_nxt     = out_sym_r;
    out_verdict_nxt = out_verdict_r;
    out_last_nxt    = out_last_r;
    if (load_out) begin
      out_valid_nxt   = 1'b1;
      out_sym_nxt     = load_sym;
      out_verdict_nxt = load_verdict;
      out_last_nxt    = load_last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[AW-1:0]] <= in_prefix_char[SYM_W-1:0];
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_r       <= RES_ONE;
      count_r     <= '0;
      idx_r       <= '0;
      flushed_r   <= 1'b0;
      err_r       <= 1'b0;
      pend_end_r  <= 1'b0;
      cnt_r       <= '0;
      mode_r      <= MODE_VERIFY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_r       <= res_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      flushed_r   <= flushed_nxt;
      err_r       <= err_nxt;
      pend_end_r  <= pend_end_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_sym_r    <= pend_sym_nxt;
    out_sym_r     <= out_sym_nxt;
    out_verdict_r <= out_verdict_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_check_symbol = out_sym_r;
  assign out_verdict      = out_verdict_r;
  assign out_last         = out_last_r;

endmodule

// File: hw/rtl/gbch_checker.sv
module gbch_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input gbch_pkg::sym_t out_check_symbol,
  input logic [1:0]     out_verdict,
  input logic           out_last
);
  import gbch_pkg::*;

  // stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_check_symbol)
      && $stable(out_verdict) && $stable(out_last))
    else $error("stalled result changed");

  // only create results come in a run; every verdict other than OK ends the message
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_verdict != VERDICT_OK) |-> out_last)
    else $error("non-create verdict without last");

  // error, long-constant and invalid results carry no check symbol
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_verdict != VERDICT_OK) |-> (out_check_symbol == '0))
    else $error("check symbol on a verdict-only result");

  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind gf32_bch_checksum_engine_unit gbch_checker u_gbch_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_check_symbol (out_check_symbol),
  .out_verdict      (out_verdict),
  .out_last         (out_last)
);
